// File: src/trc_pkg.sv
`timescale 1ns / 1ps

package trc_pkg;

    // Fixed point format and search length.
    localparam int FRAC_BITS  = 20;
    localparam int ITER_LIMIT = 11;
    localparam int NCOMP      = 6;

    // Field widths.
    localparam int C_W   = 24;
    localparam int F_W   = FRAC_BITS + 1;
    localparam int TOL_W = 21;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 25;
    localparam int MB_W = 36;
    localparam int P_W  = MA_W + MB_W;

    // Internal datapath widths.
    localparam int ACC_W  = 56;
    localparam int SQ_W   = 29;
    localparam int BB2_W  = 50;
    localparam int BB3_W  = 52;
    localparam int BBQ_W  = 31;
    localparam int BBBQ_W = 35;
    localparam int G_W    = 42;
    localparam int REM_W  = 53;
    localparam int QUO_W  = 2 * FRAC_BITS;
    localparam int RT_W   = 2 * FRAC_BITS + 1;
    localparam int BIT_W  = 2 * FRAC_BITS - 1;
    localparam int NUM_W  = G_W;
    localparam int DEN_W  = G_W + 1;
    localparam int DV_W   = BB3_W;
    localparam int DIVN_W = 32;
    localparam int J_W    = $clog2(ITER_LIMIT + 1);
    localparam int CNT_W  = 6;
    localparam int E_W    = 3;

    localparam int HALF = 1 << (FRAC_BITS - 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_BB,
        ST_BBB,
        ST_G0,
        ST_DIV,
        ST_SQRT,
        ST_PICK,
        ST_NORM,
        ST_FPM,
        ST_FDIV,
        ST_GF,
        ST_GEND,
        ST_OUT,
        ST_HOLD
    } state_t;

    // Row of each distinct entry of a symmetric matrix, in word order.
    function automatic logic [1:0] pair_i(input logic [E_W-1:0] e);
        logic [1:0] r;
        unique case (e)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Column of each distinct entry of a symmetric matrix, in word order.
    function automatic logic [1:0] pair_j(input logic [E_W-1:0] e);
        logic [1:0] r;
        unique case (e)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Word position of matrix element (i, j).
    function automatic logic [E_W-1:0] midx(input logic [1:0] i, input logic [1:0] j);
        logic [E_W-1:0] r;
        unique case ({i, j})
            4'b0000:           r = 3'd0;
            4'b0101:           r = 3'd1;
            4'b1010:           r = 3'd2;
            4'b0001, 4'b0100:  r = 3'd3;
            4'b0010, 4'b1000:  r = 3'd4;
            4'b0110, 4'b1001:  r = 3'd5;
            default:           r = 3'd0;
        endcase
        return r;
    endfunction

    // g = one - round(9 t2 / 2) + 9 t3.
    function automatic logic signed [G_W-1:0] gsum(input logic [BBQ_W-1:0] t2,
                                                   input logic signed [BBBQ_W-1:0] t3);
        logic [BBQ_W+4:0]      n2;
        logic signed [G_W-1:0] h;
        logic signed [G_W-1:0] k;
        n2 = ((BBQ_W+5)'(t2) << 3) + (BBQ_W+5)'(t2) + (BBQ_W+5)'(1);
        h  = G_W'(n2 >> 1);
        k  = (G_W'(t3) <<< 3) + G_W'(t3);
        return G_W'(1 << FRAC_BITS) - h + k;
    endfunction

endpackage

// File: src/trc_if.sv
`timescale 1ns / 1ps

// Tensor word channel.
interface trc_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [trc_pkg::C_W-1:0]  comp_xx;
    logic signed [trc_pkg::C_W-1:0]  comp_yy;
    logic signed [trc_pkg::C_W-1:0]  comp_zz;
    logic signed [trc_pkg::C_W-1:0]  comp_xy;
    logic signed [trc_pkg::C_W-1:0]  comp_xz;
    logic signed [trc_pkg::C_W-1:0]  comp_yz;

    modport source (output valid, comp_xx, comp_yy, comp_zz, comp_xy, comp_xz, comp_yz,
                    input ready);
    modport sink (input valid, comp_xx, comp_yy, comp_zz, comp_xy, comp_xz, comp_yz,
                  output ready);
endinterface

// Result word channel.
interface trc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [trc_pkg::C_W-1:0]    out_xx;
    logic signed [trc_pkg::C_W-1:0]    out_yy;
    logic signed [trc_pkg::C_W-1:0]    out_zz;
    logic signed [trc_pkg::C_W-1:0]    out_xy;
    logic signed [trc_pkg::C_W-1:0]    out_xz;
    logic signed [trc_pkg::C_W-1:0]    out_yz;
    logic        [trc_pkg::TOL_W-1:0]  scale;
    logic                              clipped;

    modport source (output valid, out_xx, out_yy, out_zz, out_xy, out_xz, out_yz, scale,
                    clipped, input ready);
    modport sink (input valid, out_xx, out_yy, out_zz, out_xy, out_xz, out_yz, scale,
                  clipped, output ready);
endinterface

// File: src/tensor_realizability_clip_core.sv
`timescale 1ns / 1ps
// A tensor that passes unchanged is squared, normed, cubed, tested and scaled. A clipped one
// also runs up to eleven search steps, after a 40-step divide and a 20-step square root when
// its norm is too large.
// Words are taken one at a time; the next word is taken in the cycle after the result
// register is loaded, which waits while an earlier result is not taken.
// Reset (rst_n, asynchronous, active low) idles the sequencer, drops the result word and
// sets the tolerance register to 1049.
module tensor_realizability_clip_core (
    input  logic                          clk,
    input  logic                          rst_n,
    trc_in_if.sink                        tensor,
    trc_out_if.source                     result,
    input  logic                          cfg_wr_en,
    input  logic [trc_pkg::TOL_W-1:0]     cfg_wr_data
);

    localparam logic [trc_pkg::E_W-1:0]   E_LAST   = trc_pkg::E_W'(trc_pkg::NCOMP - 1);
    localparam logic [trc_pkg::F_W-1:0]   ONE_F    = trc_pkg::F_W'(1 << trc_pkg::FRAC_BITS);
    localparam logic [trc_pkg::BB3_W-1:0] BB_LIMIT =
        trc_pkg::BB3_W'(2) << (2 * trc_pkg::FRAC_BITS);
    localparam logic [trc_pkg::CNT_W-1:0] DIV_LAST  = trc_pkg::CNT_W'(2 * trc_pkg::FRAC_BITS - 1);
    localparam logic [trc_pkg::CNT_W-1:0] SQRT_LAST = trc_pkg::CNT_W'(trc_pkg::FRAC_BITS - 1);
    localparam logic [trc_pkg::CNT_W-1:0] FDIV_LAST = trc_pkg::CNT_W'(trc_pkg::FRAC_BITS);
    localparam logic [trc_pkg::J_W-1:0]   J_LAST    = trc_pkg::J_W'(trc_pkg::ITER_LIMIT - 1);

    // Control registers.
    trc_pkg::state_t               state_reg, state_next;
    logic [trc_pkg::E_W-1:0]       e_reg, e_next;
    logic [1:0]                    k_reg, k_next;
    logic                          ph_reg, ph_next;
    logic [trc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [trc_pkg::J_W-1:0]       j_reg, j_next;
    logic                          init_reg, init_next;
    logic                          ovalid_reg, ovalid_next;
    logic [trc_pkg::TOL_W-1:0]     tol_reg, tol_next;

    // Datapath registers.
    logic signed [trc_pkg::C_W-1:0]    c_reg [trc_pkg::NCOMP];
    logic signed [trc_pkg::C_W-1:0]    c_next [trc_pkg::NCOMP];
    logic signed [trc_pkg::SQ_W-1:0]   sq_reg [trc_pkg::NCOMP];
    logic signed [trc_pkg::SQ_W-1:0]   sq_next [trc_pkg::NCOMP];
    logic signed [trc_pkg::C_W-1:0]    res_reg [trc_pkg::NCOMP];
    logic signed [trc_pkg::C_W-1:0]    res_next [trc_pkg::NCOMP];
    logic signed [trc_pkg::C_W-1:0]    o_reg [trc_pkg::NCOMP];
    logic signed [trc_pkg::C_W-1:0]    o_next [trc_pkg::NCOMP];
    logic [trc_pkg::TOL_W-1:0]         oscale_reg, oscale_next;
    logic                              oclip_reg, oclip_next;
    logic                              clip_reg, clip_next;
    logic signed [trc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [trc_pkg::BB2_W-1:0]         bb2_reg, bb2_next;
    logic [trc_pkg::BBQ_W-1:0]         bbq_reg, bbq_next;
    logic signed [trc_pkg::BBBQ_W-1:0] bbbq_reg, bbbq_next;
    logic [trc_pkg::F_W-1:0]           f_reg, f_next;
    logic [trc_pkg::F_W-1:0]           fmin_reg, fmin_next;
    logic [trc_pkg::F_W-1:0]           fmax_reg, fmax_next;
    logic [trc_pkg::F_W-1:0]           f2_reg, f2_next;
    logic [trc_pkg::F_W-1:0]           f3_reg, f3_next;
    logic [trc_pkg::BBQ_W-1:0]         t2_reg, t2_next;
    logic signed [trc_pkg::BBBQ_W-1:0] t3_reg, t3_next;
    logic signed [trc_pkg::G_W-1:0]    gmin_reg, gmin_next;
    logic signed [trc_pkg::G_W-1:0]    gmax_reg, gmax_next;
    logic [trc_pkg::NUM_W-1:0]         num_reg, num_next;
    logic [trc_pkg::DEN_W-1:0]         den_reg, den_next;
    logic [trc_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [trc_pkg::QUO_W-1:0]         quo_reg, quo_next;
    logic [trc_pkg::RT_W-1:0]          rt_reg, rt_next;
    logic [trc_pkg::BIT_W-1:0]         bit_reg, bit_next;
    logic [trc_pkg::DV_W-1:0]          dv_reg, dv_next;

    // Shared multiplier.
    logic signed [trc_pkg::MA_W-1:0]   ma;
    logic signed [trc_pkg::MB_W-1:0]   mb;
    logic signed [trc_pkg::P_W-1:0]    prod_reg;

    // Handshake outputs.
    assign tensor.ready  = (state_reg == trc_pkg::ST_IDLE);
    assign result.valid  = ovalid_reg;
    assign result.out_xx = o_reg[0];
    assign result.out_yy = o_reg[1];
    assign result.out_zz = o_reg[2];
    assign result.out_xy = o_reg[3];
    assign result.out_xz = o_reg[4];
    assign result.out_yz = o_reg[5];
    assign result.scale  = oscale_reg;
    assign result.clipped = oclip_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            trc_pkg::ST_SQ:
            begin
                ma = trc_pkg::MA_W'(c_reg[trc_pkg::midx(trc_pkg::pair_i(e_reg), k_reg)]);
                mb = trc_pkg::MB_W'(c_reg[trc_pkg::midx(k_reg, trc_pkg::pair_j(e_reg))]);
            end
            trc_pkg::ST_BB:
            begin
                ma = trc_pkg::MA_W'(c_reg[e_reg]);
                mb = trc_pkg::MB_W'(c_reg[e_reg]);
            end
            trc_pkg::ST_BBB:
            begin
                ma = trc_pkg::MA_W'(c_reg[e_reg]);
                mb = trc_pkg::MB_W'(sq_reg[e_reg]);
            end
            trc_pkg::ST_GF:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        ma = trc_pkg::MA_W'(f_reg);
                        mb = trc_pkg::MB_W'(f_reg);
                    end
                    2'd1:
                    begin
                        ma = trc_pkg::MA_W'(f2_reg);
                        mb = trc_pkg::MB_W'(bbq_reg);
                    end
                    2'd2:
                    begin
                        ma = trc_pkg::MA_W'(f2_reg);
                        mb = trc_pkg::MB_W'(f_reg);
                    end
                    default:
                    begin
                        ma = trc_pkg::MA_W'(f3_reg);
                        mb = trc_pkg::MB_W'(bbbq_reg);
                    end
                endcase
            end
            trc_pkg::ST_FPM:
            begin
                ma = trc_pkg::MA_W'($signed({1'b0, fmax_reg}) - $signed({1'b0, fmin_reg}));
                mb = trc_pkg::MB_W'({1'b0, num_reg[trc_pkg::DIVN_W-1:0]});
            end
            trc_pkg::ST_OUT:
            begin
                ma = trc_pkg::MA_W'(c_reg[e_reg]);
                mb = trc_pkg::MB_W'(f_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        logic signed [trc_pkg::P_W-1:0]   prnd;
        logic signed [trc_pkg::ACC_W-1:0] w;
        logic signed [trc_pkg::ACC_W-1:0] s_sum;
        logic signed [trc_pkg::ACC_W-1:0] s_rnd;
        logic signed [trc_pkg::G_W-1:0]   gv;
        logic signed [trc_pkg::G_W-1:0]   tol_g;
        logic [trc_pkg::BB3_W-1:0]        tb;
        logic                             le;
        logic                             clip;
        logic                             stop;
        logic [trc_pkg::REM_W-1:0]        r2;
        logic                             qb;
        logic [trc_pkg::QUO_W-1:0]        quo_n;
        logic [trc_pkg::RT_W-1:0]         trial;
        logic [trc_pkg::RT_W-1:0]         rt_n;
        logic [trc_pkg::F_W:0]            fsum;

        state_next  = state_reg;
        e_next      = e_reg;
        k_next      = k_reg;
        ph_next     = ph_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        init_next   = init_reg;
        ovalid_next = ovalid_reg;
        tol_next    = tol_reg;
        c_next      = c_reg;
        sq_next     = sq_reg;
        res_next    = res_reg;
        o_next      = o_reg;
        oscale_next = oscale_reg;
        oclip_next  = oclip_reg;
        clip_next   = clip_reg;
        acc_next    = acc_reg;
        bb2_next    = bb2_reg;
        bbq_next    = bbq_reg;
        bbbq_next   = bbbq_reg;
        f_next      = f_reg;
        fmin_next   = fmin_reg;
        fmax_next   = fmax_reg;
        f2_next     = f2_reg;
        f3_next     = f3_reg;
        t2_next     = t2_reg;
        t3_next     = t3_reg;
        gmin_next   = gmin_reg;
        gmax_next   = gmax_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        rt_next     = rt_reg;
        bit_next    = bit_reg;
        dv_next     = dv_reg;

        // Round half up of the product to the fixed point grid.
        prnd  = (prod_reg + trc_pkg::P_W'(trc_pkg::HALF)) >>> trc_pkg::FRAC_BITS;
        w     = trc_pkg::ACC_W'(prod_reg);
        if (e_reg > 3'd2)
        begin
            w = w <<< 1;
        end
        s_sum = acc_reg + w;
        s_rnd = (s_sum + trc_pkg::ACC_W'(trc_pkg::HALF)) >>> trc_pkg::FRAC_BITS;
        gv    = trc_pkg::gsum(t2_reg, t3_reg);
        tol_g = $signed({(trc_pkg::G_W - trc_pkg::TOL_W)'(0), tol_reg});
        tb    = (trc_pkg::BB3_W'(bb2_reg) << 1) + trc_pkg::BB3_W'(bb2_reg);
        le    = (tb <= BB_LIMIT);
        clip  = 1'b0;
        stop  = 1'b0;
        r2    = '0;
        qb    = 1'b0;
        quo_n = '0;
        trial = rt_reg + trc_pkg::RT_W'(bit_reg);
        rt_n  = '0;
        fsum  = {1'b0, fmin_reg} + {1'b0, fmax_reg};

        // Result word leaves when taken.
        if (result.ready)
        begin
            ovalid_next = 1'b0;
        end

        // Tolerance register write.
        if (cfg_wr_en)
        begin
            tol_next = cfg_wr_data;
        end

        unique case (state_reg)
            trc_pkg::ST_IDLE:
            begin
                if (tensor.valid)
                begin
                    c_next[0]  = tensor.comp_xx;
                    c_next[1]  = tensor.comp_yy;
                    c_next[2]  = tensor.comp_zz;
                    c_next[3]  = tensor.comp_xy;
                    c_next[4]  = tensor.comp_xz;
                    c_next[5]  = tensor.comp_yz;
                    e_next     = '0;
                    k_next     = '0;
                    ph_next    = 1'b0;
                    acc_next   = '0;
                    state_next = trc_pkg::ST_SQ;
                end
            end

            // Distinct entries of B*B, three products each.
            trc_pkg::ST_SQ:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    s_sum = acc_reg + trc_pkg::ACC_W'(prod_reg);
                    s_rnd = (s_sum + trc_pkg::ACC_W'(trc_pkg::HALF)) >>> trc_pkg::FRAC_BITS;
                    if (k_reg == 2'd2)
                    begin
                        sq_next[e_reg] = trc_pkg::SQ_W'(s_rnd);
                        acc_next       = '0;
                        k_next         = '0;
                        if (e_reg == E_LAST)
                        begin
                            e_next     = '0;
                            state_next = trc_pkg::ST_BB;
                        end
                        else
                        begin
                            e_next = e_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        acc_next = s_sum;
                        k_next   = k_reg + 2'd1;
                    end
                end
            end

            // Squared norm; off-diagonal terms count twice.
            trc_pkg::ST_BB:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (e_reg == E_LAST)
                    begin
                        bb2_next   = trc_pkg::BB2_W'(s_sum);
                        bbq_next   = trc_pkg::BBQ_W'(s_rnd);
                        acc_next   = '0;
                        e_next     = '0;
                        state_next = trc_pkg::ST_BBB;
                    end
                    else
                    begin
                        acc_next = s_sum;
                        e_next   = e_reg + 3'd1;
                    end
                end
            end

            // Trace of the cube.
            trc_pkg::ST_BBB:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (e_reg == E_LAST)
                    begin
                        bbbq_next  = trc_pkg::BBBQ_W'(s_rnd);
                        e_next     = '0;
                        state_next = trc_pkg::ST_G0;
                    end
                    else
                    begin
                        acc_next = s_sum;
                        e_next   = e_reg + 3'd1;
                    end
                end
            end

            // Realizability test at scale one and bracket set-up.
            trc_pkg::ST_G0:
            begin
                gv        = trc_pkg::gsum(bbq_reg, bbbq_reg);
                clip      = !(le && !gv[trc_pkg::G_W-1]);
                clip_next = clip;
                fmin_next = '0;
                gmin_next = trc_pkg::G_W'(1 << trc_pkg::FRAC_BITS);
                fmax_next = ONE_F;
                gmax_next = gv;
                f_next    = ONE_F;
                j_next    = '0;
                e_next    = '0;
                ph_next   = 1'b0;
                cnt_next  = '0;
                if (!clip)
                begin
                    state_next = trc_pkg::ST_OUT;
                end
                else if (!le)
                begin
                    rem_next   = trc_pkg::REM_W'(1) << (2 * trc_pkg::FRAC_BITS + 1);
                    quo_next   = '0;
                    dv_next    = tb;
                    state_next = trc_pkg::ST_DIV;
                end
                else
                begin
                    state_next = trc_pkg::ST_PICK;
                end
            end

            // Restoring divide of two by three times the norm, one bit a cycle.
            trc_pkg::ST_DIV:
            begin
                r2 = rem_reg << 1;
                if (r2 >= trc_pkg::REM_W'(dv_reg))
                begin
                    r2 = r2 - trc_pkg::REM_W'(dv_reg);
                    qb = 1'b1;
                end
                quo_n    = {quo_reg[trc_pkg::QUO_W-2:0], qb};
                rem_next = r2;
                quo_next = quo_n;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    rem_next   = trc_pkg::REM_W'(quo_n);
                    rt_next    = '0;
                    bit_next   = trc_pkg::BIT_W'(1) << (2 * trc_pkg::FRAC_BITS - 2);
                    cnt_next   = '0;
                    state_next = trc_pkg::ST_SQRT;
                end
            end

            // Integer square root, one result bit a cycle.
            trc_pkg::ST_SQRT:
            begin
                if (trc_pkg::REM_W'(trial) <= rem_reg)
                begin
                    rem_next = rem_reg - trc_pkg::REM_W'(trial);
                    rt_n     = (rt_reg >> 1) + trc_pkg::RT_W'(bit_reg);
                end
                else
                begin
                    rt_n = rt_reg >> 1;
                end
                rt_next  = rt_n;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    fmax_next  = trc_pkg::F_W'(rt_n);
                    f_next     = trc_pkg::F_W'(rt_n);
                    init_next  = 1'b1;
                    cnt_next   = '0;
                    ph_next    = 1'b0;
                    state_next = trc_pkg::ST_GF;
                end
            end

            // Choose the next trial factor.
            trc_pkg::ST_PICK:
            begin
                cnt_next   = '0;
                ph_next    = 1'b0;
                state_next = trc_pkg::ST_GF;
                if (j_reg[0])
                begin
                    f_next = trc_pkg::F_W'(fsum >> 1);
                end
                else if (gmin_reg[trc_pkg::G_W-1] || gmin_reg == '0)
                begin
                    f_next = fmin_reg;
                end
                else if (!gmax_reg[trc_pkg::G_W-1])
                begin
                    f_next = fmax_reg;
                end
                else
                begin
                    num_next   = trc_pkg::NUM_W'(gmin_reg);
                    den_next   = trc_pkg::DEN_W'(gmin_reg) - trc_pkg::DEN_W'(gmax_reg);
                    state_next = trc_pkg::ST_NORM;
                end
            end

            // Narrow the false position operands until the divisor fits 32 bits.
            trc_pkg::ST_NORM:
            begin
                if (|den_reg[trc_pkg::DEN_W-1:trc_pkg::DIVN_W])
                begin
                    den_next = den_reg >> 1;
                    num_next = num_reg >> 1;
                end
                else
                begin
                    ph_next    = 1'b0;
                    state_next = trc_pkg::ST_FPM;
                end
            end

            // Bracket width times the narrowed numerator.
            trc_pkg::ST_FPM:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    rem_next   = trc_pkg::REM_W'(prod_reg);
                    dv_next    = {den_reg[trc_pkg::DIVN_W-1:0], trc_pkg::FRAC_BITS'(0)};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = trc_pkg::ST_FDIV;
                end
            end

            // Quotient of the interpolation, one bit a cycle.
            trc_pkg::ST_FDIV:
            begin
                r2 = rem_reg;
                if (r2 >= trc_pkg::REM_W'(dv_reg))
                begin
                    r2 = r2 - trc_pkg::REM_W'(dv_reg);
                    qb = 1'b1;
                end
                quo_n    = {quo_reg[trc_pkg::QUO_W-2:0], qb};
                rem_next = r2;
                quo_next = quo_n;
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FDIV_LAST)
                begin
                    f_next     = fmin_reg + trc_pkg::F_W'(quo_n);
                    cnt_next   = '0;
                    ph_next    = 1'b0;
                    state_next = trc_pkg::ST_GF;
                end
            end

            // Powers of f and the two terms of g.
            trc_pkg::ST_GF:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    case (cnt_reg[1:0])
                        2'd0:    f2_next = trc_pkg::F_W'(prnd);
                        2'd1:    t2_next = trc_pkg::BBQ_W'(prnd);
                        2'd2:    f3_next = trc_pkg::F_W'(prnd);
                        default:
                        begin
                            t3_next    = trc_pkg::BBBQ_W'(prnd);
                            state_next = trc_pkg::ST_GEND;
                        end
                    endcase
                end
            end

            // Form g and move the bracket.
            trc_pkg::ST_GEND:
            begin
                if (init_reg)
                begin
                    gmax_next  = gv;
                    init_next  = 1'b0;
                    state_next = trc_pkg::ST_PICK;
                end
                else
                begin
                    if (!gv[trc_pkg::G_W-1] && gv != '0)
                    begin
                        fmin_next = f_reg;
                        gmin_next = gv;
                    end
                    else
                    begin
                        fmax_next = f_reg;
                        gmax_next = gv;
                    end
                    stop = (!gv[trc_pkg::G_W-1] && gv < tol_g) || (j_reg == J_LAST);
                    if (stop)
                    begin
                        if (gv[trc_pkg::G_W-1])
                        begin
                            f_next = fmin_reg;
                        end
                        e_next     = '0;
                        ph_next    = 1'b0;
                        state_next = trc_pkg::ST_OUT;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = trc_pkg::ST_PICK;
                    end
                end
            end

            // Scale the six components.
            trc_pkg::ST_OUT:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    res_next[e_reg] = trc_pkg::C_W'(prnd);
                    if (e_reg == E_LAST)
                    begin
                        e_next     = '0;
                        state_next = trc_pkg::ST_HOLD;
                    end
                    else
                    begin
                        e_next = e_reg + 3'd1;
                    end
                end
            end

            // Hand the finished word to the output register.
            trc_pkg::ST_HOLD:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    o_next      = res_reg;
                    oscale_next = f_reg;
                    oclip_next  = clip_reg;
                    ovalid_next = 1'b1;
                    state_next  = trc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = trc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= trc_pkg::ST_IDLE;
            e_reg      <= '0;
            k_reg      <= '0;
            ph_reg     <= 1'b0;
            cnt_reg    <= '0;
            j_reg      <= '0;
            init_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            tol_reg    <= trc_pkg::TOL_W'(1049);
        end
        else
        begin
            state_reg  <= state_next;
            e_reg      <= e_next;
            k_reg      <= k_next;
            ph_reg     <= ph_next;
            cnt_reg    <= cnt_next;
            j_reg      <= j_next;
            init_reg   <= init_next;
            ovalid_reg <= ovalid_next;
            tol_reg    <= tol_next;
        end
    end

    // Datapath state.
    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        sq_reg     <= sq_next;
        res_reg    <= res_next;
        o_reg      <= o_next;
        oscale_reg <= oscale_next;
        oclip_reg  <= oclip_next;
        clip_reg   <= clip_next;
        acc_reg    <= acc_next;
        bb2_reg    <= bb2_next;
        bbq_reg    <= bbq_next;
        bbbq_reg   <= bbbq_next;
        f_reg      <= f_next;
        fmin_reg   <= fmin_next;
        fmax_reg   <= fmax_next;
        f2_reg     <= f2_next;
        f3_reg     <= f3_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        gmin_reg   <= gmin_next;
        gmax_reg   <= gmax_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        rt_reg     <= rt_next;
        bit_reg    <= bit_next;
        dv_reg     <= dv_next;
    end

endmodule
